### rtl/core/hhpd_pkg.sv
// Shared types and constants for the heading-hold PID drive block.
`timescale 1ns / 1ps

package hhpd_pkg;

	// Command codes carried on the cmd field.
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ENGAGE = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// What the last stage does to the drive levels for one item.
	typedef enum logic [1:0] {
		ACT_KEEP,
		ACT_SPEED,
		ACT_STOP,
		ACT_STEER
	} act_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PROP_GAIN     = 2'd0,
		REG_INTEGRAL_GAIN = 2'd1,
		REG_BASE_POWER    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	localparam int GAIN_W     = 16;
	localparam int POWER_W    = 8;
	localparam int ANGLE_W    = 16;
	localparam int ERR_W      = ANGLE_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int CFG_W      = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CORR_W     = 10;
	localparam int DRIVE_W    = POWER_W + 3;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET     = 16'd256;
	localparam logic [GAIN_W-1:0]  INTEGRAL_GAIN_RESET = 16'd0;
	localparam logic [POWER_W-1:0] BASE_POWER_RESET    = 8'd200;
	localparam logic [POWER_W-1:0] POWER_MAX           = 8'd255;

	// Output queue geometry.
	localparam int OUT_DEPTH = 8;
	localparam int PTR_W     = 3;
	localparam int CNT_W     = 4;

	// Per-item control that travels down the pipeline.
	typedef struct packed {
		logic               valid;
		act_t               act;
		logic               holding;
		logic [POWER_W-1:0] speed;
	} pid_ctl_t;

	// One result item.
	typedef struct packed {
		logic [POWER_W-1:0] left;
		logic [POWER_W-1:0] right;
		logic               holding;
	} drive_t;

endpackage

### rtl/core/hhpd_corr.sv
// Correction pipeline: gain products, sum, rounding shift and drive level clamp.
`timescale 1ns / 1ps

module hhpd_corr import hhpd_pkg::*; #(
	parameter int SUM_WIDTH      = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [GAIN_W-1:0]           prop_gain,
	input  logic [GAIN_W-1:0]           integral_gain,
	input  logic [POWER_W-1:0]          base_power,
	input  pid_ctl_t                    ctl_s1,
	input  logic signed [ERR_W-1:0]     err_s1,
	input  logic signed [SUM_WIDTH-1:0] sum_s1,
	input  logic signed [DIFF_W-1:0]    diff_s1,
	output logic                        drive_valid,
	output drive_t                      drive
);

	localparam int P_W   = GAIN_W + 1 + ERR_W;
	localparam int I_W   = GAIN_W + 1 + SUM_WIDTH;
	localparam int D_W   = DIFF_W + GAIN_FRAC_BITS;
	localparam int NUM_W = SUM_WIDTH + 19;
	localparam int SH    = GAIN_FRAC_BITS + 6;

	pid_ctl_t                ctl_s2, ctl_s3;
	logic signed [P_W-1:0]   p_s2;
	logic signed [I_W-1:0]   i_s2;
	logic signed [D_W-1:0]   d_s2;
	logic signed [NUM_W-1:0] num_s3;

	logic signed [NUM_W-1:0]   bias;
	logic signed [NUM_W-1:0]   biased;
	logic signed [NUM_W-1:0]   corr_full;
	logic [NUM_W-CORR_W:0]     corr_hi;
	logic signed [CORR_W-1:0]  corr;
	logic signed [DRIVE_W-1:0] left_w, right_w;
	logic [POWER_W-1:0]        left_c, right_c;
	logic [POWER_W-1:0]        left_q, right_q;
	logic [POWER_W-1:0]        left_d, right_d;

	// Stage 2: the three weighted terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= $signed({1'b0, prop_gain}) * err_s1;
		i_s2 <= $signed({1'b0, integral_gain}) * sum_s1;
		d_s2 <= {diff_s1, {GAIN_FRAC_BITS{1'b0}}};
	end

	// Stage 3: numerator of the correction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_s3 <= NUM_W'(p_s2) + NUM_W'(i_s2) + NUM_W'(d_s2);
	end

	// Stage 4: divide with truncation toward zero, saturate, then clamp both sides.
	always_comb begin
		bias      = {{(NUM_W-SH){1'b0}}, {SH{num_s3[NUM_W-1]}}};
		biased    = num_s3 + bias;
		corr_full = biased >>> SH;
		corr_hi   = corr_full[NUM_W-1:CORR_W-1];
		if ((&corr_hi) || !(|corr_hi)) begin
			corr = corr_full[CORR_W-1:0];
		end else if (corr_full[NUM_W-1]) begin
			corr = {1'b1, {(CORR_W-1){1'b0}}};
		end else begin
			corr = {1'b0, {(CORR_W-1){1'b1}}};
		end
		left_w  = $signed({3'b000, base_power}) - DRIVE_W'(corr);
		right_w = $signed({3'b000, base_power}) + DRIVE_W'(corr);
		if (left_w[DRIVE_W-1]) begin
			left_c = '0;
		end else if (|left_w[DRIVE_W-2:POWER_W]) begin
			left_c = POWER_MAX;
		end else begin
			left_c = left_w[POWER_W-1:0];
		end
		if (right_w[DRIVE_W-1]) begin
			right_c = '0;
		end else if (|right_w[DRIVE_W-2:POWER_W]) begin
			right_c = POWER_MAX;
		end else begin
			right_c = right_w[POWER_W-1:0];
		end
	end

	// Next drive levels for the item in the last stage.
	always_comb begin
		unique case (ctl_s3.act)
			ACT_KEEP: begin
				left_d  = left_q;
				right_d = right_q;
			end
			ACT_SPEED: begin
				left_d  = ctl_s3.speed;
				right_d = ctl_s3.speed;
			end
			ACT_STOP: begin
				left_d  = '0;
				right_d = '0;
			end
			ACT_STEER: begin
				left_d  = left_c;
				right_d = right_c;
			end
			default: begin
				left_d  = left_q;
				right_d = right_q;
			end
		endcase
	end

	// Drive levels persist between items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (ctl_s3.valid) begin
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

	assign drive_valid   = ctl_s3.valid;
	assign drive.left    = left_d;
	assign drive.right   = right_d;
	assign drive.holding = ctl_s3.holding;

endmodule

### rtl/core/hhpd_out_fifo.sv
// Small result queue that decouples the pipeline from the output handshake.
`timescale 1ns / 1ps

module hhpd_out_fifo import hhpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  drive_t wr_data,
	input  logic   rd_en,
	output logic   not_empty,
	output drive_t rd_data
);

	drive_t           mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// Storage is written in order; no reset needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

endmodule

### rtl/core/heading_hold_pid_drive.sv
// Heading-hold PID drive: top level with command decode, loop state and handshakes.
//
// Usage: items arrive on in_valid/in_ready with cmd, angle and speed. Engage
// (while off) latches the angle as the target heading and drives both motors
// at speed; tick (while engaged) runs one PID step; stop zeroes both drives.
// Each item yields exactly one result on out_valid/out_ready carrying the
// left and right drive levels and the holding flag.
// A result passes the stage 1, 2 and 3 registers and the output queue before
// it shows on out_valid. While in_ready is high, one item is accepted every
// cycle: the loop state (target, error sum, prior error) updates in the
// acceptance cycle, and the gain multiplies, numerator sum and clamp run in
// three further pipeline stages.
// Results wait in an eight-entry output queue; in_ready drops only when eight
// items are outstanding, so a stalled receiver backs up the input after the
// queue fills and no result is lost.
// The user writes configuration (cfg_we, cfg_addr, cfg_wdata) only while idle; the block does not enforce it.
// Reset sets the gains to 1.0 and 0.0, base power to 200, turns the loop off
// and clears both drive levels and all queues.
`timescale 1ns / 1ps

module heading_hold_pid_drive import hhpd_pkg::*; #(
	parameter int SUM_WIDTH      = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                cmd,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic [POWER_W-1:0]        speed,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [POWER_W-1:0]        left_power,
	output logic [POWER_W-1:0]        right_power,
	output logic                      holding
);

	logic [GAIN_W-1:0]  prop_gain_q, integral_gain_q;
	logic [POWER_W-1:0] base_power_q;

	logic                        hold_q;
	logic signed [ANGLE_W-1:0]   target_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [ERR_W-1:0]     prior_q;
	logic [CNT_W-1:0]            pending_q;

	logic                        accept, deliver;
	logic signed [ERR_W-1:0]     err;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_sat;
	logic signed [DIFF_W-1:0]    diff;
	act_t                        act_d;

	pid_ctl_t                    ctl_s1;
	logic signed [ERR_W-1:0]     err_s1;
	logic signed [SUM_WIDTH-1:0] sum_s1;
	logic signed [DIFF_W-1:0]    diff_s1;

	logic   drive_valid;
	drive_t drive, out_item;

	assign accept  = in_valid && in_ready;
	assign deliver = out_valid && out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= PROP_GAIN_RESET;
			integral_gain_q <= INTEGRAL_GAIN_RESET;
			base_power_q    <= BASE_POWER_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_PROP_GAIN:     prop_gain_q     <= cfg_wdata;
				REG_INTEGRAL_GAIN: integral_gain_q <= cfg_wdata;
				REG_BASE_POWER:    base_power_q    <= cfg_wdata[POWER_W-1:0];
				REG_UNUSED:        ;
				default:           ;
			endcase
		end
	end

	// Error, saturated running sum and error difference.
	always_comb begin
		err      = {target_q[ANGLE_W-1], target_q} - {angle[ANGLE_W-1], angle};
		sum_wide = {sum_q[SUM_WIDTH-1], sum_q}
			+ {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
				: {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_WIDTH-1:0];
		end
		diff = {err[ERR_W-1], err} - {prior_q[ERR_W-1], prior_q};
	end

	// Command decode into the action for the drive stage.
	always_comb begin
		unique case (cmd_t'(cmd))
			CMD_ENGAGE: act_d = hold_q ? ACT_KEEP : ACT_SPEED;
			CMD_STOP:   act_d = ACT_STOP;
			CMD_TICK:   act_d = hold_q ? ACT_STEER : ACT_KEEP;
			CMD_NOP:    act_d = ACT_KEEP;
			default:    act_d = ACT_KEEP;
		endcase
	end

	// Loop state updates as each item is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= 1'b0;
			target_q <= '0;
			sum_q    <= '0;
			prior_q  <= '0;
		end else if (accept) begin
			unique case (act_d)
				ACT_SPEED: begin
					hold_q   <= 1'b1;
					target_q <= angle;
					sum_q    <= '0;
					prior_q  <= '0;
				end
				ACT_STOP: begin
					hold_q <= 1'b0;
				end
				ACT_STEER: begin
					sum_q   <= sum_sat;
					prior_q <= err;
				end
				ACT_KEEP: ;
				default: ;
			endcase
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid   <= accept;
			ctl_s1.act     <= act_d;
			ctl_s1.holding <= (act_d == ACT_SPEED) || (hold_q && (act_d != ACT_STOP));
			ctl_s1.speed   <= speed;
		end
	end

	always_ff @(posedge clk) begin
		err_s1  <= err;
		sum_s1  <= sum_sat;
		diff_s1 <= diff;
	end

	// Items accepted and not yet delivered; bounds the output queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept && !deliver) begin
			pending_q <= pending_q + CNT_W'(1);
		end else if (deliver && !accept) begin
			pending_q <= pending_q - CNT_W'(1);
		end
	end

	assign in_ready = (pending_q < CNT_W'(OUT_DEPTH));

	hhpd_corr #(
		.SUM_WIDTH      (SUM_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_corr (
		.clk           (clk),
		.arst_n        (arst_n),
		.prop_gain     (prop_gain_q),
		.integral_gain (integral_gain_q),
		.base_power    (base_power_q),
		.ctl_s1        (ctl_s1),
		.err_s1        (err_s1),
		.sum_s1        (sum_s1),
		.diff_s1       (diff_s1),
		.drive_valid   (drive_valid),
		.drive         (drive)
	);

	hhpd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (drive_valid),
		.wr_data   (drive),
		.rd_en     (deliver),
		.not_empty (out_valid),
		.rd_data   (out_item)
	);

	assign left_power  = out_item.left;
	assign right_power = out_item.right;
	assign holding     = out_item.holding;

endmodule

### rtl/core/hhpd_check.sv
// Port-level checks for the heading-hold PID drive, bound to the top level.
`timescale 1ns / 1ps

module hhpd_check import hhpd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [POWER_W-1:0] left_power,
	input logic [POWER_W-1:0] right_power,
	input logic               holding
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_power) && $stable(right_power)
			&& $stable(holding))
		else $error("result changed while stalled");

	// With the loop off both motors are stopped.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !holding |-> left_power == '0 && right_power == '0)
		else $error("drive nonzero with loop off");

	// Requires that the input backs up only while a result is offered on out_valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

bind heading_hold_pid_drive hhpd_check u_hhpd_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_power  (left_power),
	.right_power (right_power),
	.holding     (holding)
);
